// ===== rtl/ntd_pkg.sv =====
// Package for the nibble token decompressor: types, codes and the per-nibble
// decode function used by ntd_decode. No dependencies.
`default_nettype none

package ntd_pkg;

  localparam int unsigned TOK_W  = 120;  // 15 token bytes
  localparam int unsigned CNT_W  = 16;
  localparam logic [3:0]  NIB_ESC = 4'hf;

  // configuration register indexes
  localparam logic [1:0] CFG_TOKENS_LOW  = 2'd0;
  localparam logic [1:0] CFG_TOKENS_HIGH = 2'd1;
  localparam logic [1:0] CFG_OUTPUT_SIZE = 2'd2;

  localparam logic [CNT_W-1:0] OUTPUT_SIZE_RST = 16'd10496;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_WAIT_HI = 3'b010,
    PH_WAIT_LO = 3'b100
  } phase_e;

  typedef struct packed {
    phase_e           phase;
    logic [3:0]       lit;
    logic [CNT_W-1:0] count;
  } nib_state_t;

  localparam nib_state_t ST_RESET = '{phase: PH_IDLE, lit: 4'd0, count: '0};

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_t;

  typedef struct packed {
    logic       emit;
    out_t       res;
    nib_state_t nxt;
  } nib_out_t;

  // results of one input byte, compacted to the front
  typedef struct packed {
    logic [1:0] num;
    out_t       r0;
    out_t       r1;
  } res_t;

  function automatic logic [7:0] token_at(logic [TOK_W-1:0] tokens, logic [3:0] nib);
    logic [6:0] idx;
    logic [7:0] t;
    idx = {nib, 3'b000};
    t   = 8'd0;
    if (nib != NIB_ESC) begin
      t = tokens[idx +: 8];
    end
    return t;
  endfunction

  function automatic nib_out_t step_nibble(nib_state_t st, logic [3:0] nib,
                                           logic [TOK_W-1:0] tokens,
                                           logic [CNT_W-1:0] osize);
    nib_out_t         r;
    logic [CNT_W-1:0] cnt_inc;
    r.emit     = 1'b0;
    r.res.data = 8'd0;
    r.res.last = 1'b0;
    r.nxt      = st;
    cnt_inc    = st.count + 16'd1;
    unique case (st.phase)
      PH_WAIT_HI: begin
        r.nxt.lit   = nib;
        r.nxt.phase = PH_WAIT_LO;
      end
      PH_WAIT_LO: begin
        r.nxt.phase = PH_IDLE;
        r.emit      = 1'b1;
        r.res.data  = {st.lit, nib};
      end
      default: begin
        r.nxt.phase = PH_IDLE;
        if (nib == NIB_ESC) begin
          r.nxt.phase = PH_WAIT_HI;
        end else begin
          r.emit     = 1'b1;
          r.res.data = token_at(tokens, nib);
        end
      end
    endcase
    if (r.emit) begin
      r.nxt.count = cnt_inc;
      r.res.last  = (cnt_inc == osize);
      if (r.res.last) begin
        r.nxt = ST_RESET;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ntd_decode.sv =====
// Decode of one packed byte: high nibble, then low nibble unless the high one
// ended the stream. Combinational; uses ntd_pkg.
`default_nettype none

module ntd_decode (
  input  ntd_pkg::nib_state_t          st_i,
  input  logic [7:0]                   packed_byte_i,
  input  logic [ntd_pkg::TOK_W-1:0]    tokens_i,
  input  logic [ntd_pkg::CNT_W-1:0]    output_size_i,
  output ntd_pkg::res_t                res_o,
  output ntd_pkg::nib_state_t          st_o
);
  import ntd_pkg::*;

  nib_out_t hi_out;
  nib_out_t lo_out;
  logic     stop_after_hi;

  assign hi_out        = step_nibble(st_i, packed_byte_i[7:4], tokens_i, output_size_i);
  assign stop_after_hi = hi_out.emit & hi_out.res.last;
  assign lo_out        = step_nibble(hi_out.nxt, packed_byte_i[3:0], tokens_i,
                                     output_size_i);

  always_comb begin
    res_o.num = 2'd0;
    res_o.r0  = hi_out.res;
    res_o.r1  = lo_out.res;
    st_o      = lo_out.nxt;
    if (stop_after_hi) begin
      // low nibble is dropped after the final byte
      res_o.num = 2'd1;
      st_o      = hi_out.nxt;
    end else if (hi_out.emit) begin
      res_o.num = lo_out.emit ? 2'd2 : 2'd1;
    end else begin
      res_o.r0  = lo_out.res;
      res_o.num = lo_out.emit ? 2'd1 : 2'd0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/nibble_token_decompressor_core.sv =====
// Top level of the nibble token decompressor: config registers, decode state
// and a two-entry result buffer. Uses ntd_pkg and ntd_decode.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-----------------------------
//   in      | input     | in_valid_i / in_stall_o | packed_byte_i
//   out     | output    | out_valid_o/out_stall_i | out_byte_o, is_last_o
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// A byte is decoded in the cycle it is accepted; its 0..2 results appear on the
// output the next cycle, one transfer per cycle unless out_stall_i is high. The
// two-entry result buffer sets the rate: one byte per cycle when bytes yield at
// most one result and out_stall_i is low. A new byte is taken while the last
// buffered result transfers. Reset clears state, buffer and registers
// (output_size to 10496). cfg_ready_o is always high.
`default_nettype none

module nibble_token_decompressor_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  packed_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  out_byte_o,
  output logic                        is_last_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [1:0]                  cfg_index_i,
  input  logic [63:0]                 cfg_data_i
);
  import ntd_pkg::*;

  logic [63:0]      tokens_low_q;
  logic [55:0]      tokens_high_q;
  logic [CNT_W-1:0] output_size_q;

  nib_state_t st_q, st_d;
  res_t       dec_res;

  out_t       buf_q [2];
  logic [1:0] cnt_q;

  logic in_xfer;
  logic out_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tokens_low_q  <= '0;
      tokens_high_q <= '0;
      output_size_q <= OUTPUT_SIZE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_TOKENS_LOW:  tokens_low_q  <= cfg_data_i;
        CFG_TOKENS_HIGH: tokens_high_q <= cfg_data_i[55:0];
        CFG_OUTPUT_SIZE: output_size_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  ntd_decode u_decode (
    .st_i          (st_q),
    .packed_byte_i (packed_byte_i),
    .tokens_i      ({tokens_high_q, tokens_low_q}),
    .output_size_i (output_size_q),
    .res_o         (dec_res),
    .st_o          (st_d)
  );

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_byte_o  = buf_q[0].data;
  assign is_last_o   = buf_q[0].last;
  assign out_pop     = out_valid_o & ~out_stall_i;
  // room once the buffer is empty or drains its last entry this cycle
  assign in_stall_o  = ~((cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_pop));
  assign in_xfer     = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_RESET;
      cnt_q <= 2'd0;
    end else if (in_xfer) begin
      st_q  <= st_d;
      cnt_q <= dec_res.num;
    end else if (out_pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      buf_q[0] <= dec_res.r0;
      buf_q[1] <= dec_res.r1;
    end else if (out_pop) begin
      buf_q[0] <= buf_q[1];
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result buffer count out of range");

  a_token_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (st_q.phase == PH_IDLE) && (packed_byte_i[7:4] != NIB_ESC))
      |=> (cnt_q != 2'd0))
    else $error("token nibble produced no result");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (dec_res.num != 2'd0) && dec_res.r0.last)
      |=> ((st_q.count == '0) && (st_q.phase == PH_IDLE)))
    else $error("state not cleared after final byte");

endmodule

`default_nettype wire

// ===== verif/nibble_token_decompressor_core_test.sv =====
// Self-checking testbench for nibble_token_decompressor_core: directed and random
// compressed bytes, a cycle-free decode predictor and field-by-field output checks.
// Depends on ntd_pkg and the core RTL only.
`timescale 1ns / 100ps

module nibble_token_decompressor_core_test;
  import ntd_pkg::*;

  localparam logic [1:0]  CFG_NONE      = 2'd3;  // unmapped index, must be ignored
  localparam int unsigned QUIET_LIMIT   = 1000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned MAX_REPORTS   = 40;
  localparam int unsigned RAND_PHASES   = 6;
  localparam int unsigned PHASE_ITEMS   = 130;

  localparam logic [7:0] DIR_A [17] = '{
    8'h00, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9a, 8'hbc, 8'hde, 8'he0,
    8'hf5, 8'ha0, 8'h0f, 8'hff, 8'hff, 8'h00, 8'hf0, 8'h0f
  };
  localparam logic [7:0] DIR_B [4] = '{8'hf1, 8'h2f, 8'h3f, 8'h7e};

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic [7:0]  packed_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic [7:0]  out_byte_o;
  logic        is_last_o;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i   = 2'd0;
  logic [63:0] cfg_data_i    = 64'd0;

  nibble_token_decompressor_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .packed_byte_i(packed_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .is_last_o    (is_last_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // decoder shadow: configuration and stream state
  logic [63:0] tok_lo    = '0;
  logic [55:0] tok_hi    = '0;
  logic [15:0] osize     = OUTPUT_SIZE_RST;
  phase_e      esc_phase = PH_IDLE;
  logic [3:0]  lit_hi    = '0;
  logic [15:0] emitted   = '0;

  out_t        pending_bytes [$];
  logic [7:0]  packed_q [$];
  int unsigned n_queued   = 0;
  int unsigned n_accepted = 0;
  int unsigned n_checked  = 0;
  int unsigned n_last     = 0;
  int unsigned n_cfg      = 0;
  int unsigned err_cnt    = 0;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cnt  = 0;
  bit          idle_on    = 1'b0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
  endtask

  function automatic int unsigned draw_wait();
    return idle_on ? $urandom_range(0, 8) : 0;
  endfunction

  function automatic logic [7:0] token_byte(logic [3:0] n);
    if (n < 4'd8) begin
      return tok_lo[n*8 +: 8];
    end
    return tok_hi[(n-8)*8 +: 8];
  endfunction

  // counts one decoded byte; returns 1 when it closes the stream
  function automatic bit push_result(logic [7:0] b);
    out_t r;
    emitted = emitted + 16'd1;
    r.data  = b;
    r.last  = (emitted == osize);
    pending_bytes.push_back(r);
    if (r.last) begin
      emitted   = '0;
      esc_phase = PH_IDLE;
      lit_hi    = '0;
      n_last++;
    end
    return r.last;
  endfunction

  function automatic bit decode_nibble(logic [3:0] n);
    bit done;
    done = 1'b0;
    case (esc_phase)
      PH_WAIT_HI: begin
        lit_hi    = n;
        esc_phase = PH_WAIT_LO;
      end
      PH_WAIT_LO: begin
        esc_phase = PH_IDLE;
        done      = push_result({lit_hi, n});
      end
      default: begin
        esc_phase = PH_IDLE;
        if (n == NIB_ESC) begin
          esc_phase = PH_WAIT_HI;
        end else begin
          done = push_result(token_byte(n));
        end
      end
    endcase
    return done;
  endfunction

  // low nibble is dropped when the high nibble ended the stream
  function automatic void predict_byte(logic [7:0] b);
    if (!decode_nibble(b[7:4])) begin
      void'(decode_nibble(b[3:0]));
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : drive_in
    int unsigned w;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left   <= 0;
    end else if (in_valid_i && !in_stall_o) begin
      predict_byte(packed_byte_i);
      n_accepted++;
      w = draw_wait();
      // the cycle after the transfer already counts toward the idle gap
      gap_left <= (w == 0) ? 0 : w - 1;
      if (w == 0 && packed_q.size() != 0) begin
        packed_byte_i <= packed_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end else if (!in_valid_i) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
      end else if (packed_q.size() != 0) begin
        packed_byte_i <= packed_q.pop_front();
        in_valid_i    <= 1'b1;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : drive_stall
    int unsigned w;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (out_valid_o && !out_stall_i) begin
      w = draw_wait();
      stall_left  <= w;
      out_stall_i <= (w != 0);
    end else if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= (stall_left != 1);
    end
  end

  always @(posedge clk_i) begin : check_out
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_checked++;
      if (pending_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %0b", out_byte_o, is_last_o));
      end else begin
        want = pending_bytes.pop_front();
        if (out_byte_o !== want.data) begin
          report_mismatch($sformatf("out_byte %02h, want %02h", out_byte_o, want.data));
        end
        if (is_last_o !== want.last) begin
          report_mismatch($sformatf("is_last %0b, want %0b (byte %02h)",
                                    is_last_o, want.last, want.data));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cnt <= 0;
      end else if (quiet_cnt == QUIET_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cnt <= quiet_cnt + 1;
      end
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_TOKENS_LOW:  tok_lo = val;
      CFG_TOKENS_HIGH: tok_hi = val[55:0];
      CFG_OUTPUT_SIZE: osize  = val[15:0];
      default: ;
    endcase
    n_cfg++;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic queue_byte(logic [7:0] b);
    packed_q.push_back(b);
    n_queued++;
  endtask

  // all bytes taken and all results seen, then allow for a trailing escape nibble
  task automatic wait_idle();
    do @(posedge clk_i); while (n_accepted != n_queued || pending_bytes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [3:0] draw_nibble(bit allow_esc);
    if (allow_esc && $urandom_range(0, 3) == 0) begin
      return NIB_ESC;
    end
    return 4'($urandom_range(0, 14));
  endfunction

  function automatic logic [63:0] rand64();
    return {32'($urandom), 32'($urandom)};
  endfunction

  initial begin
    logic [15:0] sz;
    logic [63:0] hdr;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: every token, escapes across byte boundaries, ends mid-byte
    cfg_write(CFG_NONE, rand64());
    cfg_write(CFG_TOKENS_LOW, 64'h8877_6655_4433_2211);
    cfg_write(CFG_TOKENS_HIGH, 64'ha5ff_eedd_ccbb_aa99);
    cfg_write(CFG_OUTPUT_SIZE, 64'hffff_ffff_ffff_0005);
    foreach (DIR_A[k]) queue_byte(DIR_A[k]);
    wait_idle();
    cfg_write(CFG_OUTPUT_SIZE, 64'd1);
    foreach (DIR_B[k]) queue_byte(DIR_B[k]);
    wait_idle();

    for (int unsigned p = 0; p < RAND_PHASES; p++) begin
      idle_on = (p % 2 == 0);
      case (p)
        1: begin
          cfg_write(CFG_TOKENS_LOW, '0);
          cfg_write(CFG_TOKENS_HIGH, '0);
        end
        2: begin
          cfg_write(CFG_TOKENS_LOW, '1);
          cfg_write(CFG_TOKENS_HIGH, '1);
        end
        default: begin
          cfg_write(CFG_TOKENS_LOW, rand64());
          cfg_write(CFG_TOKENS_HIGH, rand64());
        end
      endcase
      if (p == 3) cfg_write(CFG_NONE, rand64());
      case (p)
        0:       sz = 16'd2;
        1:       sz = 16'hffff;
        2:       sz = 16'($urandom_range(1, 6));
        default: sz = 16'($urandom_range(1, 40));
      endcase
      hdr = rand64();
      cfg_write(CFG_OUTPUT_SIZE, {hdr[63:16], sz});
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 7) == 0) begin
          queue_byte(8'($urandom_range(0, 255)));
        end else begin
          queue_byte({draw_nibble(1'b1), draw_nibble(1'b1)});
        end
      end
      wait_idle();
    end

    // size lowered below the running count: the count runs on, no byte is last
    idle_on = 1'b0;
    cfg_write(CFG_OUTPUT_SIZE, 64'd300);
    repeat (20) queue_byte({draw_nibble(1'b0), draw_nibble(1'b0)});
    wait_idle();
    cfg_write(CFG_OUTPUT_SIZE, 64'd20);
    repeat (20) queue_byte({draw_nibble(1'b0), draw_nibble(1'b0)});
    wait_idle();

    if (pending_bytes.size() != 0) begin
      report_mismatch($sformatf("%0d expected bytes never arrived", pending_bytes.size()));
    end
    $display("covered %0d compressed bytes and %0d register writes", n_accepted, n_cfg);
    $display("checked %0d decoded bytes across %0d stream ends", n_checked, n_last);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
